// ----- rtl/usbpd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usbpd_pkg
// Shared types and codes for the USB PD capabilities list decoder.
// ---------------------------------------------------------------------------
package usbpd_pkg;

    localparam int unsigned MAX_PDOS = 7;

    localparam logic [1:0] HEADER_BYTES_RST = 2'd1;

    // supply kind codes
    localparam logic [2:0] KIND_FIXED    = 3'd0;
    localparam logic [2:0] KIND_BATTERY  = 3'd1;
    localparam logic [2:0] KIND_VARIABLE = 3'd2;
    localparam logic [2:0] KIND_PPS      = 3'd3;
    localparam logic [2:0] KIND_AVS      = 3'd4;
    localparam logic [2:0] KIND_NONE     = 3'd5;

    // list status codes
    localparam logic [2:0] ST_PROGRESS = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BADLEN   = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_NOLIST   = 3'd4;

    // PDO type field (bits 31:30) and APDO subtype (bits 29:28)
    localparam logic [1:0] TOP_FIXED    = 2'd0;
    localparam logic [1:0] TOP_BATTERY  = 2'd1;
    localparam logic [1:0] TOP_VARIABLE = 2'd2;
    localparam logic [1:0] TOP_APDO     = 2'd3;
    localparam logic [1:0] APDO_PPS     = 2'd0;
    localparam logic [1:0] APDO_AVS     = 2'd2;

    localparam logic REQ_HEADER = 1'b0;

    typedef enum logic [0:0] {
        S_IDLE,
        S_CALC
    } state_t;

    typedef struct packed {
        logic load_in;   // capture input beat and decode
        logic load_out;  // update list state and output register
    } ctrl_cmd_t;

endpackage

// ----- rtl/usbpd_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usbpd_ctrl
// Handshake controller: accept, compute, hand result to the output register.
// ---------------------------------------------------------------------------
module usbpd_ctrl
    import usbpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                // output register free, or its beat leaves this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_in_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_CALC)
        else $error("accepted beat did not move to compute state");
    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result loaded but output not valid");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && out_valid_reg && !out_ready) |=> state_reg == S_CALC)
        else $error("result overwrote a stalled output beat");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_in && cmd.load_out))
        else $error("accept and load in the same cycle");
`endif

endmodule

// ----- rtl/usbpd_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usbpd_datapath
// PDO decode, power product, list tracking and output registers.
// ---------------------------------------------------------------------------
module usbpd_datapath
    import usbpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    input  logic        req_type,
    input  logic [7:0]  count_byte,
    input  logic [7:0]  buffer_length,
    input  logic [31:0] pdo_word,
    output logic        pdo_valid,
    output logic [2:0]  supply_kind,
    output logic [15:0] nominal_mv,
    output logic [15:0] range_min_mv,
    output logic [15:0] range_max_mv,
    output logic [13:0] limit_ma,
    output logic [18:0] supply_mw,
    output logic [2:0]  pdo_position,
    output logic [2:0]  list_status,
    output logic [15:0] list_peak_mv,
    output logic        dual_role_power,
    output logic        list_done
);

    // configuration and list state
    logic [1:0]  header_bytes_reg;
    logic        phase_reg, phase_next;
    logic [2:0]  expected_reg, expected_next;
    logic [2:0]  received_reg, received_next;
    logic [15:0] run_max_reg, run_max_next;
    logic        dual_reg, dual_next;

    // stage 1: captured beat and decoded word
    logic        req_reg;
    logic [2:0]  count_reg;
    logic [7:0]  blen_reg;
    logic        dec_valid_reg;
    logic [2:0]  dec_kind_reg;
    logic [15:0] dec_volt_reg, dec_vmin_reg, dec_vmax_reg;
    logic [13:0] dec_cur_reg;
    logic [18:0] dec_pwr_reg;
    logic        drp_bit_reg;

    logic        dec_valid;
    logic [2:0]  dec_kind;
    logic [15:0] dec_volt, dec_vmin, dec_vmax;
    logic [13:0] dec_cur;
    logic [18:0] dec_pwr;
    logic [9:0]  mul_a, mul_b;
    logic [19:0] prod;

    // output register
    logic        o_valid_reg, o_valid_next;
    logic [2:0]  o_kind_reg, o_kind_next;
    logic [15:0] o_volt_reg, o_volt_next;
    logic [15:0] o_vmin_reg, o_vmin_next;
    logic [15:0] o_vmax_reg, o_vmax_next;
    logic [13:0] o_cur_reg, o_cur_next;
    logic [18:0] o_pwr_reg, o_pwr_next;
    logic [2:0]  o_pos_reg, o_pos_next;
    logic [2:0]  o_status_reg, o_status_next;
    logic [15:0] o_max_reg, o_max_next;
    logic        o_dual_reg, o_dual_next;
    logic        o_done_reg, o_done_next;

    logic [5:0]  need;
    logic        bad_len;
    logic [15:0] new_max;
    logic        new_dual;
    logic [2:0]  rc_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= HEADER_BYTES_RST;
        end
        else if (cfg_write_en)
        begin
            header_bytes_reg <= cfg_write_data;
        end
    end

    // decode; fixed/variable power is (50 mV * a)(10 mA * b)/1000 = a*b/2,
    // PPS is (100 mV * a)(50 mA * b)/1000 = 5*a*b
    always_comb
    begin
        dec_valid = 1'b0;
        dec_kind  = KIND_NONE;
        dec_volt  = '0;
        dec_vmin  = '0;
        dec_vmax  = '0;
        dec_cur   = '0;
        dec_pwr   = '0;
        mul_a     = '0;
        mul_b     = '0;
        case (pdo_word[31:30])
            TOP_FIXED:
            begin
                mul_a = pdo_word[19:10];
                mul_b = pdo_word[9:0];
            end
            TOP_VARIABLE:
            begin
                mul_a = pdo_word[29:20];
                mul_b = pdo_word[9:0];
            end
            TOP_APDO:
            begin
                mul_a = {2'b00, pdo_word[24:17]};
                mul_b = {3'b000, pdo_word[6:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 20'(mul_a) * 20'(mul_b);
        if (pdo_word != 32'd0)
        begin
            case (pdo_word[31:30])
                TOP_FIXED:
                begin
                    dec_valid = 1'b1;
                    dec_kind  = KIND_FIXED;
                    dec_volt  = 16'(pdo_word[19:10]) * 16'd50;
                    dec_vmin  = dec_volt;
                    dec_vmax  = dec_volt;
                    dec_cur   = 14'(pdo_word[9:0]) * 14'd10;
                    dec_pwr   = prod[19:1];
                end
                TOP_BATTERY:
                begin
                    dec_valid = 1'b1;
                    dec_kind  = KIND_BATTERY;
                    dec_vmin  = 16'(pdo_word[19:10]) * 16'd50;
                    dec_vmax  = 16'(pdo_word[29:20]) * 16'd50;
                    dec_volt  = dec_vmax;
                    dec_pwr   = 19'(pdo_word[9:0]) * 19'd250;
                end
                TOP_VARIABLE:
                begin
                    dec_valid = 1'b1;
                    dec_kind  = KIND_VARIABLE;
                    dec_vmin  = 16'(pdo_word[19:10]) * 16'd50;
                    dec_vmax  = 16'(pdo_word[29:20]) * 16'd50;
                    dec_volt  = dec_vmax;
                    dec_cur   = 14'(pdo_word[9:0]) * 14'd10;
                    dec_pwr   = prod[19:1];
                end
                default:
                begin
                    if (pdo_word[29:28] == APDO_PPS)
                    begin
                        dec_valid = 1'b1;
                        dec_kind  = KIND_PPS;
                        dec_vmin  = 16'(pdo_word[15:8]) * 16'd100;
                        dec_vmax  = 16'(pdo_word[24:17]) * 16'd100;
                        dec_volt  = dec_vmax;
                        dec_cur   = 14'(pdo_word[6:0]) * 14'd50;
                        dec_pwr   = 19'(prod) * 19'd5;
                    end
                    else if (pdo_word[29:28] == APDO_AVS)
                    begin
                        dec_valid = 1'b1;
                        dec_kind  = KIND_AVS;
                        dec_vmin  = 16'd9000;
                        dec_vmax  = 16'd20000;
                        dec_volt  = 16'd20000;
                        dec_cur   = 14'(pdo_word[9:0]) * 14'd10;
                        dec_pwr   = 19'(pdo_word[9:0]) * 19'd200;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg       <= req_type;
            count_reg     <= count_byte[2:0];
            blen_reg      <= buffer_length;
            dec_valid_reg <= dec_valid;
            dec_kind_reg  <= dec_kind;
            dec_volt_reg  <= dec_volt;
            dec_vmin_reg  <= dec_vmin;
            dec_vmax_reg  <= dec_vmax;
            dec_cur_reg   <= dec_cur;
            dec_pwr_reg   <= dec_pwr;
            drp_bit_reg   <= pdo_word[29];
        end
    end

    // stage 2: list bookkeeping
    always_comb
    begin
        need     = 6'(header_bytes_reg) + {1'b0, count_reg, 2'b00};
        bad_len  = (blen_reg < 8'(header_bytes_reg)) || (blen_reg < 8'(need))
                   || (count_reg > 3'(MAX_PDOS));
        new_max  = (dec_vmax_reg > run_max_reg) ? dec_vmax_reg : run_max_reg;
        new_dual = (received_reg == 3'd0 && dec_kind_reg == KIND_FIXED)
                   ? drp_bit_reg : dual_reg;
        rc_inc   = received_reg + 3'd1;

        phase_next    = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        run_max_next  = run_max_reg;
        dual_next     = dual_reg;

        o_valid_next  = dec_valid_reg;
        o_kind_next   = dec_kind_reg;
        o_volt_next   = dec_volt_reg;
        o_vmin_next   = dec_vmin_reg;
        o_vmax_next   = dec_vmax_reg;
        o_cur_next    = dec_cur_reg;
        o_pwr_next    = dec_pwr_reg;
        o_pos_next    = 3'd0;
        o_status_next = ST_PROGRESS;
        o_max_next    = '0;
        o_dual_next   = 1'b0;
        o_done_next   = 1'b0;

        if (req_reg == REQ_HEADER)
        begin
            o_valid_next  = 1'b0;
            o_kind_next   = KIND_NONE;
            o_volt_next   = '0;
            o_vmin_next   = '0;
            o_vmax_next   = '0;
            o_cur_next    = '0;
            o_pwr_next    = '0;
            phase_next    = 1'b0;
            expected_next = '0;
            received_next = '0;
            run_max_next  = '0;
            dual_next     = 1'b0;
            if (bad_len)
            begin
                o_status_next = ST_BADLEN;
                o_done_next   = 1'b1;
            end
            else if (count_reg == 3'd0)
            begin
                o_status_next = ST_OK;
                o_done_next   = 1'b1;
            end
            else
            begin
                expected_next = count_reg;
                phase_next    = 1'b1;
            end
        end
        else if (!phase_reg)
        begin
            // stray word: decoded, state untouched
            o_status_next = ST_NOLIST;
        end
        else if (!dec_valid_reg)
        begin
            phase_next    = 1'b0;
            expected_next = '0;
            received_next = '0;
            run_max_next  = '0;
            dual_next     = 1'b0;
            o_pos_next    = received_reg;
            o_status_next = ST_INVALID;
            o_done_next   = 1'b1;
        end
        else
        begin
            run_max_next  = new_max;
            dual_next     = new_dual;
            received_next = rc_inc;
            o_pos_next    = received_reg;
            o_max_next    = new_max;
            o_dual_next   = new_dual;
            if (rc_inc >= expected_reg)
            begin
                phase_next    = 1'b0;
                o_status_next = ST_OK;
                o_done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            expected_reg <= '0;
            received_reg <= '0;
            run_max_reg  <= '0;
            dual_reg     <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            run_max_reg  <= run_max_next;
            dual_reg     <= dual_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_valid_reg  <= o_valid_next;
            o_kind_reg   <= o_kind_next;
            o_volt_reg   <= o_volt_next;
            o_vmin_reg   <= o_vmin_next;
            o_vmax_reg   <= o_vmax_next;
            o_cur_reg    <= o_cur_next;
            o_pwr_reg    <= o_pwr_next;
            o_pos_reg    <= o_pos_next;
            o_status_reg <= o_status_next;
            o_max_reg    <= o_max_next;
            o_dual_reg   <= o_dual_next;
            o_done_reg   <= o_done_next;
        end
    end

    assign pdo_valid       = o_valid_reg;
    assign supply_kind     = o_kind_reg;
    assign nominal_mv      = o_volt_reg;
    assign range_min_mv    = o_vmin_reg;
    assign range_max_mv    = o_vmax_reg;
    assign limit_ma        = o_cur_reg;
    assign supply_mw       = o_pwr_reg;
    assign pdo_position    = o_pos_reg;
    assign list_status     = o_status_reg;
    assign list_peak_mv    = o_max_reg;
    assign dual_role_power = o_dual_reg;
    assign list_done       = o_done_reg;

`ifndef SYNTHESIS
    a_open_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (expected_reg != 3'd0 && received_reg < expected_reg))
        else $error("open list with inconsistent counts");
    a_max_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && req_reg != REQ_HEADER && phase_reg && dec_valid_reg)
        |=> run_max_reg >= $past(run_max_reg))
        else $error("running maximum decreased inside a list");
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && o_done_next) |=> !phase_reg)
        else $error("list still open after done");
`endif

endmodule

// ----- rtl/usb_pd_capabilities_decoder_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usb_pd_capabilities_decoder_core
// USB PD capabilities list decoder: header check and per-PDO decode.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: a list
//   header (req_type 0: count_byte, buffer_length) or one PDO word
//   (req_type 1: pdo_word). Every input beat yields exactly one output beat
//   on out_valid/out_ready with the decoded supply values and list status.
//   An accepted beat is decoded in its accept cycle and captured in the
//   stage 1 registers; the list update then loads its result into the
//   output register once it is free; out_valid then rises. The next item is
//   accepted only after that load, set by the two-step decode/bookkeeping
//   sequence of the controller (accept, then list update and output load).
//   A result waiting in the output register does not block the next accept;
//   that next result waits in the compute step until the output beat is
//   taken, so a stalled receiver holds two items before in_ready stays low.
//   Write header_bytes (cfg_write_en/cfg_write_data) only while idle; the
//   block does not enforce this. Reset: no list open, counters and running
//   maximum zero, header_bytes 1, no output beat pending.
// ---------------------------------------------------------------------------
module usb_pd_capabilities_decoder_core
    import usbpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  count_byte,
    input  logic [7:0]  buffer_length,
    input  logic [31:0] pdo_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        pdo_valid,
    output logic [2:0]  supply_kind,
    output logic [15:0] nominal_mv,
    output logic [15:0] range_min_mv,
    output logic [15:0] range_max_mv,
    output logic [13:0] limit_ma,
    output logic [18:0] supply_mw,
    output logic [2:0]  pdo_position,
    output logic [2:0]  list_status,
    output logic [15:0] list_peak_mv,
    output logic        dual_role_power,
    output logic        list_done
);

    ctrl_cmd_t cmd;

    usbpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    usbpd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .req_type        (req_type),
        .count_byte      (count_byte),
        .buffer_length   (buffer_length),
        .pdo_word        (pdo_word),
        .pdo_valid       (pdo_valid),
        .supply_kind     (supply_kind),
        .nominal_mv      (nominal_mv),
        .range_min_mv    (range_min_mv),
        .range_max_mv    (range_max_mv),
        .limit_ma        (limit_ma),
        .supply_mw       (supply_mw),
        .pdo_position    (pdo_position),
        .list_status     (list_status),
        .list_peak_mv    (list_peak_mv),
        .dual_role_power (dual_role_power),
        .list_done       (list_done)
    );

endmodule

// ----- test/tb_usb_pd_capabilities_decoder_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_usb_pd_capabilities_decoder_core
// Self-checking bench for the capabilities list decoder. A directed table
// walks header checks, every supply kind and the list error paths; random
// lists follow under several header_bytes settings and idle/stall mixes.
// Every output beat is checked against a hand-typed expectation or an in-bench decoder of the list.
// ---------------------------------------------------------------------------
module tb_usb_pd_capabilities_decoder_core;
    import usbpd_pkg::*;

    localparam logic         REQ_PDO     = 1'b1;
    localparam logic [1:0]   APDO_RSVD1  = 2'd1;
    localparam logic [1:0]   APDO_RSVD3  = 2'd3;
    localparam int unsigned  CYCLE_LIMIT = 200000;
    localparam int unsigned  HOLD_CYCLES = 200;

    typedef struct packed {
        logic        pdo_valid;
        logic [2:0]  kind;
        logic [15:0] volt;
        logic [15:0] vmin;
        logic [15:0] vmax;
        logic [13:0] cur;
        logic [18:0] pwr;
        logic [2:0]  pos;
        logic [2:0]  status;
        logic [15:0] maxv;
        logic        dual;
        logic        done;
    } pd_result_t;

    typedef struct {
        logic        req;
        logic [7:0]  cnt_byte;
        logic [7:0]  blen;
        logic [31:0] word;
    } pd_item_t;

    typedef struct {
        pd_item_t   item;
        bit         typed;
        pd_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  count_byte;
    logic [7:0]  buffer_length;
    logic [31:0] pdo_word;
    logic        out_valid;
    logic        out_ready;
    logic        pdo_valid;
    logic [2:0]  supply_kind;
    logic [15:0] nominal_mv;
    logic [15:0] range_min_mv;
    logic [15:0] range_max_mv;
    logic [13:0] limit_ma;
    logic [18:0] supply_mw;
    logic [2:0]  pdo_position;
    logic [2:0]  list_status;
    logic [15:0] list_peak_mv;
    logic        dual_role_power;
    logic        list_done;

    // hand-typed expectation that travels with the input beat
    logic        in_typed;
    pd_result_t  in_typed_res;

    // list decoder state kept by the bench
    logic [1:0]  hdr_bytes;
    logic        list_open  = 1'b0;
    logic [2:0]  want_count = '0;
    logic [2:0]  got_count  = '0;
    logic [15:0] max_mv     = '0;
    logic        drp_flag   = 1'b0;

    pd_result_t  pending_results[$];
    stim_row_t   directed_rows[$];

    int          idle_pct;
    int          stall_pct;
    int          hold_reqs;
    int          hold_served = 0;
    int unsigned cycle_cnt   = 0;
    int          n_errors    = 0;
    int          n_results   = 0;
    int          n_headers   = 0;
    int          n_pdos      = 0;
    int          n_ok        = 0;
    int          n_badlen    = 0;
    int          n_invalid   = 0;
    int          n_stray     = 0;

    usb_pd_capabilities_decoder_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .count_byte      (count_byte),
        .buffer_length   (buffer_length),
        .pdo_word        (pdo_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pdo_valid       (pdo_valid),
        .supply_kind     (supply_kind),
        .nominal_mv      (nominal_mv),
        .range_min_mv    (range_min_mv),
        .range_max_mv    (range_max_mv),
        .limit_ma        (limit_ma),
        .supply_mw       (supply_mw),
        .pdo_position    (pdo_position),
        .list_status     (list_status),
        .list_peak_mv    (list_peak_mv),
        .dual_role_power (dual_role_power),
        .list_done       (list_done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic pd_result_t decode_pdo(input logic [31:0] w);
        pd_result_t  r;
        int unsigned v;
        int unsigned c;
        r = '0;
        r.kind = KIND_NONE;
        if (w == 32'd0)
            return r;
        case (w[31:30])
            TOP_FIXED:
            begin
                v = 32'(w[19:10]) * 50;
                c = 32'(w[9:0]) * 10;
                r.pdo_valid = 1'b1;
                r.kind = KIND_FIXED;
                r.volt = 16'(v);
                r.vmin = 16'(v);
                r.vmax = 16'(v);
                r.cur = 14'(c);
                r.pwr = 19'(v * c / 1000);
            end
            TOP_BATTERY:
            begin
                v = 32'(w[29:20]) * 50;
                r.pdo_valid = 1'b1;
                r.kind = KIND_BATTERY;
                r.vmin = 16'(32'(w[19:10]) * 50);
                r.vmax = 16'(v);
                r.volt = 16'(v);
                r.pwr = 19'(32'(w[9:0]) * 250);
            end
            TOP_VARIABLE:
            begin
                v = 32'(w[29:20]) * 50;
                c = 32'(w[9:0]) * 10;
                r.pdo_valid = 1'b1;
                r.kind = KIND_VARIABLE;
                r.vmin = 16'(32'(w[19:10]) * 50);
                r.vmax = 16'(v);
                r.volt = 16'(v);
                r.cur = 14'(c);
                r.pwr = 19'(v * c / 1000);
            end
            default:
            begin
                if (w[29:28] == APDO_PPS)
                begin
                    v = 32'(w[24:17]) * 100;
                    c = 32'(w[6:0]) * 50;
                    r.pdo_valid = 1'b1;
                    r.kind = KIND_PPS;
                    r.vmin = 16'(32'(w[15:8]) * 100);
                    r.vmax = 16'(v);
                    r.volt = 16'(v);
                    r.cur = 14'(c);
                    r.pwr = 19'(v * c / 1000);
                end
                else if (w[29:28] == APDO_AVS)
                begin
                    c = 32'(w[9:0]) * 10;
                    r.pdo_valid = 1'b1;
                    r.kind = KIND_AVS;
                    r.vmin = 16'd9000;
                    r.vmax = 16'd20000;
                    r.volt = 16'd20000;
                    r.cur = 14'(c);
                    r.pwr = 19'(20000 * c / 1000);
                end
            end
        endcase
        return r;
    endfunction

    // advances the list state by one beat and returns its result
    function automatic pd_result_t step_list(input logic req, input logic [7:0] cb,
                                             input logic [7:0] bl, input logic [31:0] w);
        pd_result_t  r;
        int unsigned cnt;
        int unsigned need;
        logic [2:0]  pos;
        if (req == REQ_HEADER)
        begin
            r = '0;
            r.kind = KIND_NONE;
            cnt = 32'(cb[2:0]);
            need = 32'(hdr_bytes) + 4 * cnt;
            list_open = 1'b0;
            got_count = '0;
            want_count = '0;
            max_mv = '0;
            drp_flag = 1'b0;
            if (32'(bl) < 32'(hdr_bytes) || 32'(bl) < need)
            begin
                r.status = ST_BADLEN;
                r.done = 1'b1;
            end
            else if (cnt == 0)
            begin
                r.status = ST_OK;
                r.done = 1'b1;
            end
            else
            begin
                want_count = 3'(cnt);
                list_open = 1'b1;
                r.status = ST_PROGRESS;
            end
            return r;
        end
        r = decode_pdo(w);
        pos = got_count;
        if (!list_open)
        begin
            // stray word: decoded, state untouched
            r.status = ST_NOLIST;
            return r;
        end
        if (!r.pdo_valid)
        begin
            list_open = 1'b0;
            got_count = '0;
            want_count = '0;
            max_mv = '0;
            drp_flag = 1'b0;
            r.pos = pos;
            r.status = ST_INVALID;
            r.done = 1'b1;
            return r;
        end
        if (r.vmax > max_mv)
            max_mv = r.vmax;
        if (pos == 3'd0 && r.kind == KIND_FIXED)
            drp_flag = w[29];
        got_count = got_count + 3'd1;
        r.pos = pos;
        r.maxv = max_mv;
        r.dual = drp_flag;
        if (got_count >= want_count)
        begin
            list_open = 1'b0;
            r.status = ST_OK;
            r.done = 1'b1;
        end
        else
        begin
            r.status = ST_PROGRESS;
        end
        return r;
    endfunction

    function automatic pd_result_t status_only(input logic [2:0] st, input logic done,
                                               input logic [2:0] pos);
        pd_result_t r;
        r = '0;
        r.kind = KIND_NONE;
        r.status = st;
        r.done = done;
        r.pos = pos;
        return r;
    endfunction

    function automatic logic [31:0] good_pdo_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(4))
            0: w[31:30] = TOP_FIXED;
            1: w[31:30] = TOP_BATTERY;
            2: w[31:30] = TOP_VARIABLE;
            3: w[31:28] = {TOP_APDO, APDO_PPS};
            default: w[31:28] = {TOP_APDO, APDO_AVS};
        endcase
        if (w == 32'd0)
            w[0] = 1'b1;
        return w;
    endfunction

    function automatic logic [31:0] bad_pdo_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(2))
            0: w = '0;
            1: w[31:28] = {TOP_APDO, APDO_RSVD1};
            default: w[31:28] = {TOP_APDO, APDO_RSVD3};
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input pd_item_t it, input bit typed, input pd_result_t res);
        if (idle_pct != 0)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        req_type      <= it.req;
        count_byte    <= it.cnt_byte;
        buffer_length <= it.blen;
        pdo_word      <= it.word;
        in_typed      <= typed;
        in_typed_res  <= res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        // let the monitor log the last accepted beat first
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_header_bytes(input logic [1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        hdr_bytes = v;
    endtask

    task automatic add_row(input logic req, input logic [7:0] cb, input logic [7:0] bl,
                           input logic [31:0] w, input bit typed, input pd_result_t res);
        stim_row_t row;
        row.item.req = req;
        row.item.cnt_byte = cb;
        row.item.blen = bl;
        row.item.word = w;
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    task automatic issue_random_lists(input int n);
        int          sent;
        int          sel;
        int          i;
        int unsigned cnt;
        int unsigned need;
        pd_item_t    it;
        sent = 0;
        while (sent < n)
        begin
            sel = $urandom_range(99);
            it.req = REQ_HEADER;
            it.cnt_byte = 8'($urandom);
            it.blen = 8'($urandom);
            it.word = $urandom;
            if (sel < 70)
            begin
                // well-formed list, sometimes cut short by a bad word or a new header
                cnt = $urandom_range(7, 1);
                need = 32'(hdr_bytes) + 4 * cnt;
                it.cnt_byte[2:0] = 3'(cnt);
                it.blen = 8'(($urandom_range(3) == 0) ? need : $urandom_range(255, need));
                send_item(it, 1'b0, '0);
                sent++;
                for (i = 0; i < cnt; i++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 4)
                        break;
                    it.req = REQ_PDO;
                    it.cnt_byte = 8'($urandom);
                    it.blen = 8'($urandom);
                    it.word = (sel < 10) ? bad_pdo_word() : good_pdo_word();
                    send_item(it, 1'b0, '0);
                    sent++;
                    if (sel < 10)
                        break;
                end
            end
            else if (sel < 78)
            begin
                cnt = $urandom_range(7, 1);
                need = 32'(hdr_bytes) + 4 * cnt;
                it.cnt_byte[2:0] = 3'(cnt);
                it.blen = 8'($urandom_range(need - 1, 0));
                send_item(it, 1'b0, '0);
                sent++;
            end
            else if (sel < 84)
            begin
                it.cnt_byte[2:0] = 3'd0;
                it.blen = 8'($urandom_range(255, 32'(hdr_bytes)));
                send_item(it, 1'b0, '0);
                sent++;
            end
            else if (sel < 92)
            begin
                it.req = REQ_PDO;
                it.word = ($urandom_range(3) == 0) ? bad_pdo_word() : good_pdo_word();
                send_item(it, 1'b0, '0);
                sent++;
            end
            else
            begin
                it.req = 1'($urandom_range(1));
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] hb, input int idle, input int stall,
                             input bit pressure, input int n);
        wait_for_results();
        write_header_bytes(hb);
        idle_pct = idle;
        stall_pct = stall;
        if (pressure)
            hold_reqs++;
        issue_random_lists(n);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_reqs)
            begin
                // long hold-off so the block backs up into its input
                hold_served = hold_reqs;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic show_result(input string tag, input pd_result_t r);
        $write("    %s: valid=%0d kind=%0d v=%0d vmin=%0d vmax=%0d i=%0d p=%0d",
               tag, r.pdo_valid, r.kind, r.volt, r.vmin, r.vmax, r.cur, r.pwr);
        $display(" pos=%0d st=%0d max=%0d drp=%0d done=%0d",
                 r.pos, r.status, r.maxv, r.dual, r.done);
    endtask

    always @(posedge clk)
    begin : accept_mon
        pd_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = step_list(req_type, count_byte, buffer_length, pdo_word);
            if (req_type == REQ_HEADER)
                n_headers++;
            else
                n_pdos++;
            case (r.status)
                ST_OK:      n_ok++;
                ST_BADLEN:  n_badlen++;
                ST_INVALID: n_invalid++;
                ST_NOLIST:  n_stray++;
                default:    ;
            endcase
            pending_results.push_back(in_typed ? in_typed_res : r);
        end
    end

    always @(posedge clk)
    begin : result_mon
        pd_result_t got;
        pd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.pdo_valid = pdo_valid;
            got.kind      = supply_kind;
            got.volt      = nominal_mv;
            got.vmin      = range_min_mv;
            got.vmax      = range_max_mv;
            got.cur       = limit_ma;
            got.pwr       = supply_mw;
            got.pos       = pdo_position;
            got.status    = list_status;
            got.maxv      = list_peak_mv;
            got.dual      = dual_role_power;
            got.done      = list_done;
            n_results++;
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                begin
                    $display("ERROR @%0t: output beat with nothing expected", $realtime);
                    show_result("actual  ", got);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("ERROR @%0t: result %0d mismatch", $realtime, n_results);
                        show_result("expected", want);
                        show_result("actual  ", got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        pd_result_t r;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        req_type       = REQ_HEADER;
        count_byte     = '0;
        buffer_length  = '0;
        pdo_word       = '0;
        in_typed       = 1'b0;
        in_typed_res   = '0;
        hdr_bytes      = HEADER_BYTES_RST;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_reqs      = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray 5 V / 3 A fixed word straight out of reset
        r = status_only(ST_NOLIST, 1'b0, 3'd0);
        r.pdo_valid = 1'b1;
        r.kind = KIND_FIXED;
        r.volt = 16'd5000;
        r.vmin = 16'd5000;
        r.vmax = 16'd5000;
        r.cur = 14'd3000;
        r.pwr = 19'd15000;
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h0001_912C, 1'b1, r);
        // header length checks with header_bytes at reset value
        add_row(REQ_HEADER, 8'h00, 8'd0, 32'hFFFF_FFFF, 1'b1, status_only(ST_BADLEN, 1'b1, 3'd0));
        add_row(REQ_HEADER, 8'h00, 8'd1, 32'h0, 1'b1, status_only(ST_OK, 1'b1, 3'd0));
        add_row(REQ_HEADER, 8'hFF, 8'd28, 32'h0, 1'b1, status_only(ST_BADLEN, 1'b1, 3'd0));
        add_row(REQ_HEADER, 8'hF8, 8'd255, 32'h0, 1'b1, status_only(ST_OK, 1'b1, 3'd0));
        add_row(REQ_HEADER, 8'h07, 8'd29, 32'h0, 1'b1, status_only(ST_PROGRESS, 1'b0, 3'd0));
        // full seven-object list: every supply kind at its field extremes
        add_row(REQ_PDO, 8'hFF, 8'hFF, 32'h3FFF_FFFF, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hBFFF_FFFF, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hCFFF_FFFF, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hEFFF_FFFF, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h0000_0001, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h8000_0000, 1'b0, '0);
        // zero word kills the list at its first position
        add_row(REQ_HEADER, 8'h02, 8'd9, 32'h0, 1'b1, status_only(ST_PROGRESS, 1'b0, 3'd0));
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h0, 1'b1, status_only(ST_INVALID, 1'b1, 3'd0));
        // reserved APDO subtype at the second position
        add_row(REQ_HEADER, 8'h03, 8'd13, 32'h0, 1'b1, status_only(ST_PROGRESS, 1'b0, 3'd0));
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h2001_912C, 1'b0, '0);
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hD0AB_CDEF, 1'b1, status_only(ST_INVALID, 1'b1, 3'd1));
        // new header while a list is still open
        add_row(REQ_HEADER, 8'h02, 8'd9, 32'h0, 1'b1, status_only(ST_PROGRESS, 1'b0, 3'd0));
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h4B43_20FA, 1'b0, '0);
        add_row(REQ_HEADER, 8'h01, 8'd5, 32'h0, 1'b1, status_only(ST_PROGRESS, 1'b0, 3'd0));
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hC1A4_640A, 1'b0, '0);
        // stray words once the list is closed
        add_row(REQ_PDO, 8'h00, 8'h00, 32'hF000_1234, 1'b1, status_only(ST_NOLIST, 1'b0, 3'd0));
        add_row(REQ_PDO, 8'h00, 8'h00, 32'h9FFF_FFFF, 1'b0, '0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

        run_phase(2'd3, 0, 0, 1'b1, 80);
        run_phase(2'd1, 65, 0, 1'b0, 80);
        run_phase(2'd2, 0, 65, 1'b0, 80);
        run_phase(2'd0, 23, 23, 1'b0, 80);
        run_phase(2'd3, 23, 23, 1'b0, 80);
        wait_for_results();

        $display("Sent %0d headers and %0d PDO beats, checked %0d results in %0d cycles",
                 n_headers, n_pdos, n_results, cycle_cnt);
        $display("Lists ok %0d, short buffer %0d, bad object %0d, stray words %0d, errors %0d",
                 n_ok, n_badlen, n_invalid, n_stray, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
